[hw/rtl/assert_macros.svh]
// assertion macros for the accumulator update rtl
// no dependencies; taken in by include where a module asserts
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

[hw/rtl/nau_pkg.sv]
// shared types, constants and feature index functions of the accumulator update unit
// no dependencies
`default_nettype none

package nau_pkg;

  localparam int LANES_DEF = 128;
  localparam int GROUP     = 16;
  localparam int LANE_W    = 16;
  localparam int LSEL_W    = 4;
  localparam int WORD_W    = GROUP * LANE_W;
  localparam int FEATURES  = 768;
  localparam int KINDS     = 6;

  localparam logic [5:0] MIRROR  = 6'd56;
  localparam logic [5:0] LAST_SQ = 6'd63;

  typedef enum logic [2:0] {
    MODE_LOAD_W  = 3'd0,
    MODE_LOAD_B  = 3'd1,
    MODE_RESET   = 3'd2,
    MODE_ADD     = 3'd3,
    MODE_REMOVE  = 3'd4,
    MODE_MOVE    = 3'd5,
    MODE_ADD_MAP = 3'd6,
    MODE_READ    = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_RD,
    ST_SWEEP,
    ST_SCAN,
    ST_READ,
    ST_FETCH,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    FN_ADD,
    FN_SUB,
    FN_COPY,
    FN_PATCH
  } func_t;

  typedef struct packed {
    logic               wr_w;
    logic               wr_s;
    logic               cap;
    func_t              func;
    logic [LSEL_W-1:0]  lane_sel;
  } op_t;

  function automatic logic [9:0] first_feature(input logic [2:0] kind, input logic side,
                                               input logic [5:0] sq);
    return {kind, ~side, sq};
  endfunction

  function automatic logic [9:0] second_feature(input logic [2:0] kind, input logic side,
                                                input logic [5:0] sq);
    return {kind, side, sq ^ MIRROR};
  endfunction

endpackage

`default_nettype wire

[hw/rtl/nau_ram.sv]
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module nau_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[hw/rtl/nau_alu.sv]
// lane datapath: add, subtract, copy or patch one memory word of sixteen lanes
// depends on nau_pkg
`default_nettype none

module nau_alu (
  input  wire nau_pkg::op_t                  op,
  input  wire logic [nau_pkg::WORD_W-1:0]    w_rdata,
  input  wire logic [nau_pkg::WORD_W-1:0]    s_rdata,
  input  wire logic                          s_ok,
  input  wire logic [nau_pkg::LANE_W-1:0]    patch_value,
  output logic      [nau_pkg::WORD_W-1:0]    wr_data,
  output logic      [nau_pkg::LANE_W-1:0]    lane_out
);

  always_comb begin
    logic [nau_pkg::LANE_W-1:0] s_lane;
    logic [nau_pkg::LANE_W-1:0] w_lane;
    logic [nau_pkg::LANE_W-1:0] src_lane;
    wr_data = '0;
    for (int i = 0; i < nau_pkg::GROUP; i++) begin
      s_lane   = s_ok ? s_rdata[i*nau_pkg::LANE_W +: nau_pkg::LANE_W] : '0;
      w_lane   = w_rdata[i*nau_pkg::LANE_W +: nau_pkg::LANE_W];
      src_lane = op.wr_w ? w_lane : s_rdata[i*nau_pkg::LANE_W +: nau_pkg::LANE_W];
      unique case (op.func)
        nau_pkg::FN_ADD:  wr_data[i*nau_pkg::LANE_W +: nau_pkg::LANE_W] = s_lane + w_lane;
        nau_pkg::FN_SUB:  wr_data[i*nau_pkg::LANE_W +: nau_pkg::LANE_W] = s_lane - w_lane;
        nau_pkg::FN_COPY: wr_data[i*nau_pkg::LANE_W +: nau_pkg::LANE_W] = s_lane;
        nau_pkg::FN_PATCH: begin
          wr_data[i*nau_pkg::LANE_W +: nau_pkg::LANE_W] =
            (nau_pkg::LSEL_W'(i) == op.lane_sel) ? patch_value : src_lane;
        end
        default: wr_data[i*nau_pkg::LANE_W +: nau_pkg::LANE_W] = s_lane;
      endcase
    end
  end

  assign lane_out = s_ok ? s_rdata[op.lane_sel*nau_pkg::LANE_W +: nau_pkg::LANE_W] : '0;

endmodule

`default_nettype wire

[hw/rtl/nau_ctrl.sv]
// sequencer: item capture, memory address generation and write pipeline control
// depends on nau_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module nau_ctrl #(
  parameter int LANES = nau_pkg::LANES_DEF,
  localparam int WORDS     = LANES / nau_pkg::GROUP,
  localparam int W_AW      = $clog2(nau_pkg::FEATURES * WORDS),
  localparam int SUM_AW    = $clog2(3 * WORDS),
  localparam int STEP_W    = $clog2(2 * WORDS),
  localparam int WIDX_W    = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [2:0]          in_mode,
  input  wire logic [2:0]          in_piece_kind,
  input  wire logic                in_piece_side,
  input  wire logic [5:0]          in_from_square,
  input  wire logic [5:0]          in_to_square,
  input  wire logic [63:0]         in_square_map,
  input  wire logic [9:0]          in_feature_row,
  input  wire logic [6:0]          in_lane_index,
  input  wire logic                in_view_select,
  input  wire logic [15:0]         in_load_value,
  input  wire logic                out_free,
  output logic                     done,
  output logic [W_AW-1:0]          w_raddr,
  output logic [SUM_AW-1:0]        s_raddr,
  output logic [W_AW-1:0]          w_waddr,
  output logic [SUM_AW-1:0]        s_waddr,
  output nau_pkg::op_t             op,
  output logic [15:0]              patch_value
);

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(2 * WORDS - 1);
  localparam logic [SUM_AW-1:0] VIEW1_BASE = SUM_AW'(WORDS);
  localparam logic [SUM_AW-1:0] BIAS_BASE  = SUM_AW'(2 * WORDS);

  nau_pkg::state_t state_r, state_nxt;
  nau_pkg::mode_t  mode_r;
  logic [2:0]        kind_r;
  logic              side_r;
  logic [5:0]        to_r;
  logic [63:0]       map_r;
  logic [9:0]        row_r;
  logic [6:0]        lane_r;
  logic              view_r;
  logic [15:0]       value_r;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [5:0]        sq_r, sq_nxt;
  logic              sub_r, sub_nxt;
  logic              phase_r, phase_nxt;
  nau_pkg::op_t      pipe_r, pipe_nxt;
  logic [W_AW-1:0]   w_waddr_r;
  logic [SUM_AW-1:0] s_waddr_r, s_waddr_nxt;

  logic              accept;
  logic              step_view;
  logic [WIDX_W-1:0] step_word;
  logic [WIDX_W-1:0] lane_word;
  logic [9:0]        feat;
  logic [9:0]        row_sel;
  logic [WIDX_W-1:0] word_sel;
  logic [SUM_AW-1:0] view_row;
  logic              kind_ok;
  logic              lane_ok;
  logic              row_ok;

  assign accept    = in_valid && in_ready;
  assign step_view = step_r[0];
  assign step_word = WIDX_W'(step_r >> 1);
  assign lane_word = WIDX_W'(lane_r >> nau_pkg::LSEL_W);
  assign feat      = step_view ? nau_pkg::second_feature(kind_r, side_r, sq_r)
                               : nau_pkg::first_feature(kind_r, side_r, sq_r);
  assign row_sel   = (state_r == nau_pkg::ST_LOAD_RD) ? row_r : feat;
  assign word_sel  = (state_r == nau_pkg::ST_LOAD_RD) ? lane_word : step_word;
  assign w_raddr   = W_AW'(row_sel) * W_AW'(WORDS) + W_AW'(word_sel);
  assign view_row  = (step_view ? VIEW1_BASE : '0) + SUM_AW'(step_word);

  always_comb begin
    priority case (state_r)
      nau_pkg::ST_LOAD_RD: s_raddr = BIAS_BASE + SUM_AW'(lane_word);
      nau_pkg::ST_READ:    s_raddr = (view_r ? VIEW1_BASE : '0) + SUM_AW'(lane_word);
      default: begin
        s_raddr = (mode_r == nau_pkg::MODE_RESET) ? BIAS_BASE + SUM_AW'(step_word) : view_row;
      end
    endcase
  end

  assign kind_ok = in_piece_kind < 3'(nau_pkg::KINDS);
  assign lane_ok = 32'(in_lane_index) < LANES;
  assign row_ok  = in_feature_row < 10'(nau_pkg::FEATURES);

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    sq_nxt      = sq_r;
    sub_nxt     = sub_r;
    phase_nxt   = phase_r;
    pipe_nxt    = '0;
    s_waddr_nxt = s_raddr;
    in_ready    = 1'b0;
    done        = 1'b0;
    unique case (state_r)
      nau_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          step_nxt  = '0;
          phase_nxt = 1'b0;
          sub_nxt   = 1'b0;
          sq_nxt    = in_from_square;
          unique case (nau_pkg::mode_t'(in_mode))
            nau_pkg::MODE_LOAD_W: begin
              state_nxt = (row_ok && lane_ok) ? nau_pkg::ST_LOAD_RD : nau_pkg::ST_DONE;
            end
            nau_pkg::MODE_LOAD_B: begin
              state_nxt = lane_ok ? nau_pkg::ST_LOAD_RD : nau_pkg::ST_DONE;
            end
            nau_pkg::MODE_RESET: state_nxt = nau_pkg::ST_SWEEP;
            nau_pkg::MODE_ADD: begin
              state_nxt = kind_ok ? nau_pkg::ST_SWEEP : nau_pkg::ST_DONE;
            end
            nau_pkg::MODE_REMOVE, nau_pkg::MODE_MOVE: begin
              sub_nxt   = 1'b1;
              state_nxt = kind_ok ? nau_pkg::ST_SWEEP : nau_pkg::ST_DONE;
            end
            nau_pkg::MODE_ADD_MAP: begin
              sq_nxt    = '0;
              state_nxt = kind_ok ? nau_pkg::ST_SCAN : nau_pkg::ST_DONE;
            end
            nau_pkg::MODE_READ: begin
              state_nxt = lane_ok ? nau_pkg::ST_READ : nau_pkg::ST_DONE;
            end
            default: state_nxt = nau_pkg::ST_DONE;
          endcase
        end
      end
      nau_pkg::ST_LOAD_RD: begin
        pipe_nxt.wr_w     = (mode_r == nau_pkg::MODE_LOAD_W);
        pipe_nxt.wr_s     = (mode_r != nau_pkg::MODE_LOAD_W);
        pipe_nxt.func     = nau_pkg::FN_PATCH;
        pipe_nxt.lane_sel = lane_r[nau_pkg::LSEL_W-1:0];
        state_nxt         = nau_pkg::ST_DONE;
      end
      nau_pkg::ST_SWEEP: begin
        pipe_nxt.wr_s = 1'b1;
        pipe_nxt.func = (mode_r == nau_pkg::MODE_RESET) ? nau_pkg::FN_COPY :
                        (sub_r ? nau_pkg::FN_SUB : nau_pkg::FN_ADD);
        s_waddr_nxt   = view_row;
        step_nxt      = step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          step_nxt = '0;
          priority if (mode_r == nau_pkg::MODE_MOVE && !phase_r) begin
            phase_nxt = 1'b1;
            sq_nxt    = to_r;
            sub_nxt   = 1'b0;
          end else if (mode_r == nau_pkg::MODE_ADD_MAP) begin
            if (sq_r == nau_pkg::LAST_SQ) begin
              state_nxt = nau_pkg::ST_DONE;
            end else begin
              sq_nxt    = sq_r + 1'b1;
              state_nxt = nau_pkg::ST_SCAN;
            end
          end else begin
            state_nxt = nau_pkg::ST_DONE;
          end
        end
      end
      nau_pkg::ST_SCAN: begin
        priority if (map_r[sq_r]) begin
          state_nxt = nau_pkg::ST_SWEEP;
        end else if (sq_r == nau_pkg::LAST_SQ) begin
          state_nxt = nau_pkg::ST_DONE;
        end else begin
          sq_nxt = sq_r + 1'b1;
        end
      end
      nau_pkg::ST_READ: begin
        pipe_nxt.cap      = 1'b1;
        pipe_nxt.lane_sel = lane_r[nau_pkg::LSEL_W-1:0];
        state_nxt         = nau_pkg::ST_FETCH;
      end
      nau_pkg::ST_FETCH: state_nxt = nau_pkg::ST_DONE;
      nau_pkg::ST_DONE: begin
        if (out_free) begin
          done      = 1'b1;
          state_nxt = nau_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nau_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nau_pkg::ST_IDLE;
      step_r  <= '0;
      sq_r    <= '0;
      sub_r   <= 1'b0;
      phase_r <= 1'b0;
      pipe_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      sq_r    <= sq_nxt;
      sub_r   <= sub_nxt;
      phase_r <= phase_nxt;
      pipe_r  <= pipe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_waddr_r <= w_raddr;
    s_waddr_r <= s_waddr_nxt;
    if (accept) begin
      mode_r  <= nau_pkg::mode_t'(in_mode);
      kind_r  <= in_piece_kind;
      side_r  <= in_piece_side;
      to_r    <= in_to_square;
      map_r   <= in_square_map;
      row_r   <= in_feature_row;
      lane_r  <= in_lane_index;
      view_r  <= in_view_select;
      value_r <= in_load_value;
    end
  end

  assign w_waddr     = w_waddr_r;
  assign s_waddr     = s_waddr_r;
  assign op          = pipe_r;
  assign patch_value = value_r;

  `ASSERT_NEVER(a_sum_rw_same_entry, clk, rst_n,
    (state_r == nau_pkg::ST_SWEEP) && pipe_r.wr_s && (s_raddr == s_waddr_r),
    "sum entry read while its update is being written")
  `ASSERT_CLK(a_step_bound, clk, rst_n, step_r <= STEP_LAST, "step counter past last word")
  `ASSERT_CLK(a_accept_leaves_idle, clk, rst_n, accept |=> (state_r != nau_pkg::ST_IDLE),
    "accepted item left sequencer idle")
  `ASSERT_CLK(a_pipe_onehot, clk, rst_n, $onehot0({pipe_r.wr_w, pipe_r.wr_s, pipe_r.cap}),
    "more than one memory action in one pipeline slot")

endmodule

`default_nettype wire

[hw/rtl/nnue_accumulator_update_unit.sv]
// top level of the accumulator update unit: weight ram, sum ram, lane datapath
// depends on nau_pkg, nau_ram, nau_alu, nau_ctrl
//
// input channel in_valid/in_ready carries one item per handshake; each item gives
// exactly one out_lane_value item on out_valid/out_ready (zero except for a read).
// weights and the bias row are written one lane per item (load weight, load bias)
// and must be loaded before a reset-to-bias or a piece update uses them.
// state is kept sixteen lanes per memory word; every update step reads a weight
// word and a sum word and writes the sum back in the next cycle, one word a cycle.
// a sweep steps through both views word by word, W = LANES/16 words per view;
// reset to bias, add and remove sweep once; move removes at the from square, then
// adds at the to square; add map scans all 64 squares, one sweep per set square.
// the per-step rate is set by the single read port of the sum ram.
// in_ready is high while the sequencer is idle; a finished result waits in the
// output register and the next item is taken meanwhile. when out_ready stays low
// the block finishes that next item and then holds in its last state.
// synchronous reset zeroes both views at once through per-word valid bits, with
// no clearing pass; weight and bias memories keep their contents.
`default_nettype none

module nnue_accumulator_update_unit #(
  parameter int LANES = nau_pkg::LANES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_mode,
  input  wire logic [2:0]         in_piece_kind,
  input  wire logic               in_piece_side,
  input  wire logic [5:0]         in_from_square,
  input  wire logic [5:0]         in_to_square,
  input  wire logic [63:0]        in_square_map,
  input  wire logic [9:0]         in_feature_row,
  input  wire logic [6:0]         in_lane_index,
  input  wire logic               in_view_select,
  input  wire logic signed [15:0] in_load_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_lane_value
);

  localparam int WORDS     = LANES / nau_pkg::GROUP;
  localparam int W_DEPTH   = nau_pkg::FEATURES * WORDS;
  localparam int S_DEPTH   = 3 * WORDS;
  localparam int W_AW      = $clog2(W_DEPTH);
  localparam int SUM_AW    = $clog2(S_DEPTH);
  localparam int VIEW_ROWS = 2 * WORDS;
  localparam int VIEW_AW   = $clog2(VIEW_ROWS);

  logic [W_AW-1:0]             w_raddr, w_waddr;
  logic [SUM_AW-1:0]           s_raddr, s_waddr;
  logic [nau_pkg::WORD_W-1:0]  w_rdata, s_rdata, wr_data;
  logic [nau_pkg::LANE_W-1:0]  lane_out;
  logic [15:0]                 patch_value;
  nau_pkg::op_t                op;
  logic                        done;
  logic                        out_free;
  logic                        accept;
  logic [VIEW_ROWS-1:0]        valid_r;
  logic                        s_ok_r, s_ok_nxt;
  logic [15:0]                 res_r;
  logic                        out_valid_r;
  logic [15:0]                 out_val_r;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  nau_ctrl #(.LANES(LANES)) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_piece_kind  (in_piece_kind),
    .in_piece_side  (in_piece_side),
    .in_from_square (in_from_square),
    .in_to_square   (in_to_square),
    .in_square_map  (in_square_map),
    .in_feature_row (in_feature_row),
    .in_lane_index  (in_lane_index),
    .in_view_select (in_view_select),
    .in_load_value  (in_load_value),
    .out_free       (out_free),
    .done           (done),
    .w_raddr        (w_raddr),
    .s_raddr        (s_raddr),
    .w_waddr        (w_waddr),
    .s_waddr        (s_waddr),
    .op             (op),
    .patch_value    (patch_value)
  );

  nau_ram #(.WIDTH(nau_pkg::WORD_W), .DEPTH(W_DEPTH)) u_weight_ram (
    .clk     (clk),
    .wr_en   (op.wr_w),
    .wr_addr (w_waddr),
    .wr_data (wr_data),
    .rd_addr (w_raddr),
    .rd_data (w_rdata)
  );

  nau_ram #(.WIDTH(nau_pkg::WORD_W), .DEPTH(S_DEPTH)) u_sum_ram (
    .clk     (clk),
    .wr_en   (op.wr_s),
    .wr_addr (s_waddr),
    .wr_data (wr_data),
    .rd_addr (s_raddr),
    .rd_data (s_rdata)
  );

  nau_alu u_alu (
    .op          (op),
    .w_rdata     (w_rdata),
    .s_rdata     (s_rdata),
    .s_ok        (s_ok_r),
    .patch_value (patch_value),
    .wr_data     (wr_data),
    .lane_out    (lane_out)
  );

  // view words never written since reset read as zero
  assign s_ok_nxt = (s_raddr >= SUM_AW'(VIEW_ROWS)) || valid_r[s_raddr[VIEW_AW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      s_ok_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s_ok_r <= s_ok_nxt;
      if (op.wr_s && (s_waddr < SUM_AW'(VIEW_ROWS))) begin
        valid_r[s_waddr[VIEW_AW-1:0]] <= 1'b1;
      end
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= '0;
    end else if (op.cap) begin
      res_r <= lane_out;
    end
    if (done) begin
      out_val_r <= res_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_lane_value = out_val_r;

endmodule

`default_nettype wire
